// ----- hdl/ktm_pkg.sv -----
// Shared types, codes and sizes of the key to MIDI note tracker.
`default_nettype none

package ktm_pkg;

    localparam int NUM_POSITIONS = 32;
    localparam int POS_W         = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int APB_ADDR_W    = 4;

    // input op codes
    localparam logic [1:0] OP_KEY   = 2'd0;
    localparam logic [1:0] OP_PANIC = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // map kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NOTE = 2'd1;
    localparam logic [1:0] KIND_CTRL = 2'd2;

    // message types
    localparam logic [1:0] MSG_NOTE_ON  = 2'd0;
    localparam logic [1:0] MSG_NOTE_OFF = 2'd1;
    localparam logic [1:0] MSG_CC       = 2'd2;
    localparam logic [1:0] MSG_ALL_OFF  = 2'd3;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TRANSPOSE = 2'd0;
    localparam logic [1:0] REG_NOTE_CH   = 2'd1;
    localparam logic [1:0] REG_CTRL_CH   = 2'd2;
    localparam logic [1:0] REG_VELOCITY  = 2'd3;

    localparam logic [6:0] MIDI_MAX       = 7'd127;
    localparam logic [6:0] VELOCITY_RESET = 7'd100;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] position;
        logic       key_down;
        logic [1:0] map_kind;
        logic [6:0] map_data;
    } t_in_word;

    typedef struct packed {
        logic [1:0] msg_type;
        logic [3:0] channel;
        logic [6:0] data1;
        logic [6:0] data2;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic signed [7:0] transpose;
        logic [3:0]        note_ch;
        logic [3:0]        ctrl_ch;
        logic [6:0]        velocity;
    } t_cfg;

    typedef enum logic [1:0] {
        CMD_KEY,
        CMD_PANIC,
        CMD_LOAD
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [4:0] position;
        logic       key_down;
        logic [1:0] map_kind;
        logic [6:0] map_data;
    } t_cmd;

endpackage

`default_nettype wire

// ----- hdl/ktm_regs.sv -----
// APB configuration registers.
`default_nettype none

module ktm_regs
    import ktm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.transpose <= '0;
            r_cfg.note_ch   <= '0;
            r_cfg.ctrl_ch   <= '0;
            r_cfg.velocity  <= VELOCITY_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TRANSPOSE: r_cfg.transpose <= pwdata[7:0];
                REG_NOTE_CH:   r_cfg.note_ch   <= pwdata[3:0];
                REG_CTRL_CH:   r_cfg.ctrl_ch   <= pwdata[3:0];
                REG_VELOCITY:  r_cfg.velocity  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TRANSPOSE: prdata = {24'd0, r_cfg.transpose};
            REG_NOTE_CH:   prdata = {28'd0, r_cfg.note_ch};
            REG_CTRL_CH:   prdata = {28'd0, r_cfg.ctrl_ch};
            REG_VELOCITY:  prdata = {25'd0, r_cfg.velocity};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/ktm_front.sv -----
// Front end: accepts input words, drops unused ops and bad positions, builds commands.
`default_nettype none

module ktm_front
    import ktm_pkg::*;
(
    input  wire logic     i_valid,
    input  wire t_in_word i_word,
    output logic          o_stall,
    input  wire logic     i_q_full,
    output logic          o_push,
    output t_cmd          o_cmd
);

    logic in_range;
    logic keep;

    assign in_range = int'(i_word.position) < NUM_POSITIONS;
    assign o_stall  = i_q_full;

    always_comb begin
        o_cmd.position = i_word.position;
        o_cmd.key_down = i_word.key_down;
        o_cmd.map_kind = i_word.map_kind;
        o_cmd.map_data = i_word.map_data;
        case (i_word.op)
            OP_KEY: begin
                o_cmd.kind = CMD_KEY;
                keep       = in_range;
            end
            OP_PANIC: begin
                o_cmd.kind = CMD_PANIC;
                keep       = 1'b1;
            end
            OP_LOAD: begin
                o_cmd.kind = CMD_LOAD;
                keep       = in_range;
            end
            default: begin
                o_cmd.kind = CMD_KEY;
                keep       = 1'b0;
            end
        endcase
    end

    // a dropped word is still accepted, it just never reaches the queue
    assign o_push = i_valid && !i_q_full && keep;

endmodule

`default_nettype wire

// ----- hdl/ktm_fifo.sv -----
// Short command queue between front end and sequencer.
`default_nettype none

module ktm_fifo
    import ktm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- hdl/ktm_back.sv -----
// Sequencer: key map, sounding-note table, panic sweep and output register.
`default_nettype none

module ktm_back
    import ktm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire t_cmd  i_q_cmd,
    input  wire logic  i_q_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_out_word  o_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_SWEEP,
        S_ALLN,
        S_ALLC
    } t_state;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_sweep, n_sweep;
    t_cmd               r_cmd, n_cmd;
    t_out_word          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [NUM_POSITIONS-1:0] r_snd_valid;
    logic [6:0]               r_snd_note [NUM_POSITIONS];
    logic [1:0]               r_kind     [NUM_POSITIONS];
    logic [6:0]               r_data     [NUM_POSITIONS];

    logic             out_free;
    logic [POS_W-1:0] key_idx;
    logic [POS_W-1:0] load_idx;
    logic [POS_W-1:0] snd_idx;
    logic [8:0]       note_sum;
    logic             note_ok;
    logic             want;
    logic             emit;
    logic             snd_set;
    logic             snd_clr;
    logic             map_wr;
    t_out_word        msg;

    assign out_free = !r_out_valid || !i_stall;
    assign key_idx  = POS_W'(r_cmd.position);
    assign load_idx = POS_W'(i_q_cmd.position);
    assign o_valid  = r_out_valid;
    assign o_word   = r_out;

    // 9-bit two's complement sum covers -128..254; in range when top bits are clear
    assign note_sum = {2'b00, r_data[key_idx]} + {i_cfg.transpose[7], i_cfg.transpose};
    assign note_ok  = note_sum[8:7] == 2'b00;

    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_cmd       = r_cmd;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        o_pop       = 1'b0;
        want        = 1'b0;
        snd_set     = 1'b0;
        snd_clr     = 1'b0;
        map_wr      = 1'b0;
        snd_idx     = key_idx;
        msg         = '0;
        emit        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_q_cmd;
                    case (i_q_cmd.kind)
                        CMD_LOAD:  map_wr = 1'b1;
                        CMD_PANIC: begin
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        CMD_KEY:   n_state = S_KEY;
                        default: ;
                    endcase
                end
            end

            S_KEY: begin
                msg.last = 1'b1;
                case (r_kind[key_idx])
                    KIND_NOTE: begin
                        msg.channel = i_cfg.note_ch;
                        if (r_cmd.key_down) begin
                            want         = !r_snd_valid[key_idx] && note_ok;
                            msg.msg_type = MSG_NOTE_ON;
                            msg.data1    = note_sum[6:0];
                            msg.data2    = i_cfg.velocity;
                            snd_set      = want && out_free;
                        end else begin
                            want         = r_snd_valid[key_idx];
                            msg.msg_type = MSG_NOTE_OFF;
                            msg.data1    = r_snd_note[key_idx];
                            snd_clr      = want && out_free;
                        end
                    end
                    KIND_CTRL: begin
                        want         = 1'b1;
                        msg.msg_type = MSG_CC;
                        msg.channel  = i_cfg.ctrl_ch;
                        msg.data1    = r_data[key_idx];
                        msg.data2    = r_cmd.key_down ? MIDI_MAX : 7'd0;
                    end
                    default: ;
                endcase
                emit = want && out_free;
                if (!want || out_free) begin
                    n_state = S_IDLE;
                end
            end

            S_SWEEP: begin
                snd_idx      = r_sweep;
                want         = r_snd_valid[r_sweep];
                msg.msg_type = MSG_NOTE_OFF;
                msg.channel  = i_cfg.note_ch;
                msg.data1    = r_snd_note[r_sweep];
                emit         = want && out_free;
                if (!want || out_free) begin
                    snd_clr = want;
                    if (r_sweep == POS_W'(NUM_POSITIONS - 1)) begin
                        n_state = S_ALLN;
                    end else begin
                        n_sweep = r_sweep + 1'b1;
                    end
                end
            end

            S_ALLN: begin
                msg.msg_type = MSG_ALL_OFF;
                msg.channel  = i_cfg.note_ch;
                msg.last     = i_cfg.ctrl_ch == i_cfg.note_ch;
                emit         = out_free;
                if (out_free) begin
                    n_state = msg.last ? S_IDLE : S_ALLC;
                end
            end

            S_ALLC: begin
                msg.msg_type = MSG_ALL_OFF;
                msg.channel  = i_cfg.ctrl_ch;
                msg.last     = 1'b1;
                emit         = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        if (emit) begin
            n_out       = msg;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_sweep <= n_sweep;
        r_cmd   <= n_cmd;
        r_out   <= n_out;
    end

    // sounding flags and map kinds are cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snd_valid <= '0;
            r_kind      <= '{default: KIND_NONE};
        end else begin
            if (snd_set) begin
                r_snd_valid[snd_idx] <= 1'b1;
            end else if (snd_clr) begin
                r_snd_valid[snd_idx] <= 1'b0;
            end
            if (map_wr) begin
                r_kind[load_idx] <= i_q_cmd.map_kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (snd_set) begin
            r_snd_note[snd_idx] <= note_sum[6:0];
        end
        if (!i_rst_n) begin
            r_data <= '{default: 7'd0};
        end else if (map_wr) begin
            r_data[load_idx] <= i_q_cmd.map_data;
        end
    end

    a_sweep_clears_all : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALLN) |-> (r_snd_valid == '0))
        else $error("sounding entry left after panic sweep");

    a_note_on_records : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && msg.msg_type == MSG_NOTE_ON) |=> r_snd_valid[$past(key_idx)])
        else $error("note-on without sounding entry");

    a_pop_only_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("command taken while busy");

    a_emit_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r_out) || !$past(emit)))
        else $error("output overwritten while stalled");

endmodule

`default_nettype wire

// ----- hdl/key_to_midi_note_tracker.sv -----
// Top level of the key to MIDI note tracker.
`default_nettype none

// Turns key events into MIDI note-on, note-off and control-change words. Each
// input word is a key event, a panic or a map load (op field); the front end
// drops unused ops and out-of-range positions at once and queues the rest in a
// two-entry command queue, so i_valid words are taken while the sequencer is
// still busy and o_stall rises only when that queue is full. The sequencer
// works one command at a time: a map load is stored when taken; a key event is
// taken, then looked up in map and sounding table and emitted; a panic sweeps the
// sounding table one position per cycle while not stalled, then sends all-notes-off
// on the note channel and, if different, the controller channel. Every result word
// waits in one output register; while i_stall holds it, the sequencer waits with
// it. o_word.last marks the final word caused by an input word; words that cause
// nothing give no output at all. Registers sit on the APB port at byte offsets 0
// transpose, 4 note channel, 8 controller channel, 12 note velocity; a note-off
// always carries the note recorded at its note-on, even if transpose changed since.
module key_to_midi_note_tracker
    import ktm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input words
    input  wire logic                  i_valid,
    input  wire t_in_word              i_word,
    output logic                       o_stall,
    // result words
    output logic                       o_valid,
    output t_out_word                  o_word,
    input  wire logic                  i_stall,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd q_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    ktm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // classify and filter
    ktm_front u_front (
        .i_valid  (i_valid),
        .i_word   (i_word),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    ktm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // map, sounding table, panic sweep, output register
    ktm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_cmd   (q_cmd),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_word    (o_word)
    );

endmodule

`default_nettype wire
